// File: rtl/core/rbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_pkg: shared types and constants of the ray/box slab test
// Holds the transfer payloads, the queue entry and the divider depth.
// ----------------------------------------------------------------------------
package rbs_pkg;

    // Number of quotient bits produced by the divider, one per stage.
    localparam int DIV_STAGES = 32;
    // Fraction bits of a slab parameter.
    localparam int T_FRAC_BITS = 16;
    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Entry face codes.
    localparam logic [1:0] NRM_LEFT   = 2'd0;
    localparam logic [1:0] NRM_RIGHT  = 2'd1;
    localparam logic [1:0] NRM_BOTTOM = 2'd2;
    localparam logic [1:0] NRM_TOP    = 2'd3;

    // Running bounds start one step beyond the saturated parameter range.
    localparam logic signed [33:0] TMIN_INIT = -34'sd2147483649;
    localparam logic signed [33:0] TMAX_INIT = 34'sd2147483648;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic        [19:0] max_fraction;
        logic signed [31:0] box_lo_x;
        logic signed [31:0] box_lo_y;
        logic signed [31:0] box_hi_x;
        logic signed [31:0] box_hi_y;
    } ray_req_t;

    typedef struct packed {
        logic        hit;
        logic [1:0]  normal_code;
        logic [19:0] fraction;
    } ray_rsp_t;

    // Classified item handed from front to back.
    typedef struct packed {
        logic signed [32:0] num_lo_x;
        logic signed [32:0] num_hi_x;
        logic signed [32:0] num_lo_y;
        logic signed [32:0] num_hi_y;
        logic signed [32:0] den_x;
        logic signed [32:0] den_y;
        logic               par_x;
        logic               par_y;
        logic               out_x;
        logic               out_y;
        logic        [19:0] max_fraction;
    } rbs_item_t;

    // Per-item side information that rides alongside the dividers.
    typedef struct packed {
        logic        par_x;
        logic        par_y;
        logic        out_x;
        logic        out_y;
        logic [19:0] max_fraction;
    } rbs_side_t;

    // Queue status seen by the top level.
    typedef struct packed {
        logic empty;
        logic full;
        logic push;
        logic pop;
    } rbs_qstat_t;

endpackage

// File: rtl/core/rbs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_front: input stage
// Registers each request, forms the slab numerators and deltas and flags
// parallel axes together with whether the start lies outside that slab.
// ----------------------------------------------------------------------------
module rbs_front
    import rbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  ray_req_t  req,
    output logic      item_valid,
    input  logic      item_ready,
    output rbs_item_t item
);

    logic      valid_reg;
    logic      valid_next;
    rbs_item_t item_reg;
    rbs_item_t item_next;
    logic      take;

    assign req_ready = ~valid_reg | item_ready;
    assign take      = req_valid & req_ready;

    // Classify the request.
    always_comb
    begin
        item_next.num_lo_x     = 33'(req.box_lo_x) - 33'(req.start_x);
        item_next.num_hi_x     = 33'(req.box_hi_x) - 33'(req.start_x);
        item_next.num_lo_y     = 33'(req.box_lo_y) - 33'(req.start_y);
        item_next.num_hi_y     = 33'(req.box_hi_y) - 33'(req.start_y);
        item_next.den_x        = 33'(req.end_x) - 33'(req.start_x);
        item_next.den_y        = 33'(req.end_y) - 33'(req.start_y);
        item_next.par_x        = (req.end_x == req.start_x);
        item_next.par_y        = (req.end_y == req.start_y);
        item_next.out_x        = (req.start_x < req.box_lo_x) | (req.box_hi_x < req.start_x);
        item_next.out_y        = (req.start_y < req.box_lo_y) | (req.box_hi_y < req.start_y);
        item_next.max_fraction = req.max_fraction;
    end

    assign valid_next = take | (valid_reg & ~item_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: rtl/core/rbs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_queue: small queue between front and back
// A register-based FIFO that lets either side stall without the other.
// ----------------------------------------------------------------------------
module rbs_queue
    import rbs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  rbs_item_t  push_item,
    output logic       pop_valid,
    input  logic       pop_ready,
    output rbs_item_t  pop_item,
    output rbs_qstat_t stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rbs_item_t       mem [DEPTH];
    logic [PW-1:0]   wptr_reg;
    logic [PW-1:0]   wptr_next;
    logic [PW-1:0]   rptr_reg;
    logic [PW-1:0]   rptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            push;
    logic            pop;
    logic            empty;
    logic            full;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(DEPTH));
    assign push  = push_valid & ~full;
    assign pop   = pop_ready & ~empty;

    // Pointer and fill count update.
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push & ~pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop & ~push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= push_item;
        end
    end

    assign push_ready = ~full;
    assign pop_valid  = ~empty;
    assign pop_item   = mem[rptr_reg];

    assign stat.empty = empty;
    assign stat.full  = full;
    assign stat.push  = push;
    assign stat.pop   = pop;

endmodule

// File: rtl/core/rbs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_div: pipelined slab parameter divider
// Computes num * 2^16 / den truncated toward zero, one quotient bit per
// stage, and saturates the result to a signed 32 bit value.
// ----------------------------------------------------------------------------
module rbs_div
    import rbs_pkg::*;
(
    input  logic               clk,
    input  logic               adv,
    input  logic signed [32:0] num,
    input  logic signed [32:0] den,
    output logic signed [31:0] t
);

    localparam int NW = 33 + T_FRAC_BITS;

    logic [32:0]            rem_reg [DIV_STAGES + 1];
    logic [DIV_STAGES-1:0]  quo_reg [DIV_STAGES + 1];
    logic [DIV_STAGES-1:0]  low_reg [DIV_STAGES + 1];
    logic [32:0]            den_reg [DIV_STAGES + 1];
    logic                   ovf_reg [DIV_STAGES + 1];
    logic                   neg_reg [DIV_STAGES + 1];

    logic [32:0]   num_mag;
    logic [32:0]   den_mag;
    logic [NW-1:0] dividend;

    // Magnitudes and sign of the quotient.
    always_comb
    begin
        num_mag  = num[32] ? 33'(-num) : 33'(num);
        den_mag  = den[32] ? 33'(-den) : 33'(den);
        dividend = {num_mag, {T_FRAC_BITS{1'b0}}};
    end

    // Entry stage: the quotient overflows 32 bits when the high part alone
    // is not below the divisor.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= 33'(dividend[NW-1:DIV_STAGES]);
            quo_reg[0] <= '0;
            low_reg[0] <= dividend[DIV_STAGES-1:0];
            den_reg[0] <= den_mag;
            ovf_reg[0] <= (33'(dividend[NW-1:DIV_STAGES]) >= den_mag);
            neg_reg[0] <= num[32] ^ den[32];
        end
    end

    // One restoring step per stage.
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_step
        logic [33:0] shifted;
        logic [33:0] diff;
        logic        less;

        always_comb
        begin
            shifted = {rem_reg[k], low_reg[k][DIV_STAGES-1]};
            diff    = shifted - {1'b0, den_reg[k]};
            less    = diff[33];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k+1] <= less ? shifted[32:0] : diff[32:0];
                quo_reg[k+1] <= {quo_reg[k][DIV_STAGES-2:0], ~less};
                low_reg[k+1] <= {low_reg[k][DIV_STAGES-2:0], 1'b0};
                den_reg[k+1] <= den_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    // Apply the sign and clamp to the signed 32 bit range.
    always_comb
    begin
        logic [DIV_STAGES-1:0] q;
        q = quo_reg[DIV_STAGES];
        if (ovf_reg[DIV_STAGES] || (neg_reg[DIV_STAGES] && q > 32'h8000_0000)
            || (!neg_reg[DIV_STAGES] && q > 32'h7FFF_FFFF))
        begin
            t = neg_reg[DIV_STAGES] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            t = neg_reg[DIV_STAGES] ? 32'(-q) : 32'(q);
        end
    end

    // Remainder of the last stage is not needed past this point.
    logic unused_rem;
    assign unused_rem = ^rem_reg[DIV_STAGES] ^ ^low_reg[DIV_STAGES] ^ ^den_reg[DIV_STAGES];

endmodule

// File: rtl/core/rbs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_back: execution stage
// Runs the four slab divisions in parallel pipelines, then merges the two
// axes into tmin, tmax and the entry face and registers the response.
// ----------------------------------------------------------------------------
module rbs_back
    import rbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  rbs_item_t item,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output ray_rsp_t  rsp
);

    logic               adv;
    logic               vld_reg [DIV_STAGES + 1];
    rbs_side_t          side_reg [DIV_STAGES + 1];
    logic               out_valid_reg;
    ray_rsp_t           out_reg;
    ray_rsp_t           out_next;
    logic signed [31:0] t_lo_x;
    logic signed [31:0] t_hi_x;
    logic signed [31:0] t_lo_y;
    logic signed [31:0] t_hi_y;

    // The whole pipeline moves when the response register can take a value.
    assign adv        = ~out_valid_reg | rsp_ready;
    assign item_ready = adv;

    rbs_div u_div_lo_x (.clk(clk), .adv(adv), .num(item.num_lo_x), .den(item.den_x),
                        .t(t_lo_x));
    rbs_div u_div_hi_x (.clk(clk), .adv(adv), .num(item.num_hi_x), .den(item.den_x),
                        .t(t_hi_x));
    rbs_div u_div_lo_y (.clk(clk), .adv(adv), .num(item.num_lo_y), .den(item.den_y),
                        .t(t_lo_y));
    rbs_div u_div_hi_y (.clk(clk), .adv(adv), .num(item.num_hi_y), .den(item.den_y),
                        .t(t_hi_y));

    // Valid bits shadow the divider stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DIV_STAGES; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= item_valid;
            for (int i = 1; i <= DIV_STAGES; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Side information shadows the divider stages.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0].par_x        <= item.par_x;
            side_reg[0].par_y        <= item.par_y;
            side_reg[0].out_x        <= item.out_x;
            side_reg[0].out_y        <= item.out_y;
            side_reg[0].max_fraction <= item.max_fraction;
            for (int i = 1; i <= DIV_STAGES; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Merge the two slabs into the response.
    always_comb
    begin
        rbs_side_t          sd;
        logic               swap_x;
        logic               swap_y;
        logic signed [33:0] ent_x;
        logic signed [33:0] ext_x;
        logic signed [33:0] ent_y;
        logic signed [33:0] ext_y;
        logic signed [33:0] tmin;
        logic signed [33:0] tmax;
        logic [1:0]         code;
        logic               miss;

        sd     = side_reg[DIV_STAGES];
        swap_x = t_lo_x > t_hi_x;
        swap_y = t_lo_y > t_hi_y;
        ent_x  = 34'(swap_x ? t_hi_x : t_lo_x);
        ext_x  = 34'(swap_x ? t_lo_x : t_hi_x);
        ent_y  = 34'(swap_y ? t_hi_y : t_lo_y);
        ext_y  = 34'(swap_y ? t_lo_y : t_hi_y);
        tmin   = TMIN_INIT;
        tmax   = TMAX_INIT;
        code   = NRM_LEFT;
        miss   = 1'b0;

        // X axis: any real entry lies above the starting bound.
        if (sd.par_x)
        begin
            miss = sd.out_x;
        end
        else
        begin
            tmin = ent_x;
            tmax = ext_x;
            code = swap_x ? NRM_RIGHT : NRM_LEFT;
        end

        // Y axis, skipped once the ray has missed.
        if (!miss)
        begin
            if (sd.par_y)
            begin
                miss = sd.out_y;
            end
            else
            begin
                if (ent_y > tmin)
                begin
                    tmin = ent_y;
                    code = swap_y ? NRM_TOP : NRM_BOTTOM;
                end
                if (ext_y < tmax)
                begin
                    tmax = ext_y;
                end
                miss = tmin > tmax;
            end
        end

        // Entry must lie in [0, max_fraction].
        if (tmin < 0 || tmin > $signed({14'd0, sd.max_fraction}))
        begin
            miss = 1'b1;
        end

        out_next.hit         = ~miss;
        out_next.normal_code = miss ? NRM_LEFT : code;
        out_next.fraction    = miss ? 20'd0 : tmin[19:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= vld_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

// File: rtl/core/ray_box_slab_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_test: 2D ray segment against axis-aligned box
// Slab test with fixed-point division, a front classifier, a queue and a
// pipelined back end.
// ----------------------------------------------------------------------------
// The block takes one request per cycle while the output is not stalled and
// returns one response per request in order. A request passes through the
// input register, the queue, the divider pipelines (an entry stage plus one
// stage per quotient bit for 32 bits) and then the response register, which
// is loaded from the last divider stage. The queue holds two items, so the
// input keeps taking requests briefly while the output is stalled.
// Coordinates may use any fraction width since it cancels in the division.
module ray_box_slab_test
    import rbs_pkg::*;
#(
    parameter int Q_DEPTH = QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  ray_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output ray_rsp_t rsp
);

    logic       f_valid;
    logic       f_ready;
    rbs_item_t  f_item;
    logic       b_valid;
    logic       b_ready;
    rbs_item_t  b_item;
    rbs_qstat_t q_stat;

    rbs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .item_valid (f_valid),
        .item_ready (f_ready),
        .item       (f_item)
    );

    rbs_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_item   (b_item),
        .stat       (q_stat)
    );

    rbs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (b_valid),
        .item_ready (b_ready),
        .item       (b_item),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

`ifndef ASSERT_OFF
    // A miss carries a zero face code and a zero fraction.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.hit) |-> (rsp.normal_code == NRM_LEFT && rsp.fraction == 20'd0))
        else $error("miss response with nonzero fields");

    // The queue never pops when empty nor pushes when full.
    a_queue_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.pop && q_stat.empty) && !(q_stat.push && q_stat.full))
        else $error("queue overrun or underrun");

    // A push into an empty queue without a pop leaves it non-empty.
    a_queue_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (q_stat.push && !q_stat.pop) |=> !q_stat.empty)
        else $error("queue lost an item");
`endif

endmodule
